// File: rtl/nmea_command_line_receiver_top_macros.svh
// Assertion macros used by the checker of the receiver.
`ifndef NMEA_COMMAND_LINE_RECEIVER_TOP_MACROS_SVH
`define NMEA_COMMAND_LINE_RECEIVER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define NMEA_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define NMEA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// File: rtl/nmea_pkg.sv
package nmea_pkg;

  localparam int LineBuffer = 128;
  localparam int Ports      = 4;
  localparam int PortW      = 2;
  localparam int StatusW    = 3;
  localparam int CntW       = $clog2(LineBuffer);

  localparam logic [CntW-1:0] CntMax = CntW'(LineBuffer - 1);
  localparam logic [CntW-1:0] MinLen = CntW'(5);

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChX      = 8'h58;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChNul    = 8'h00;

  localparam logic [3:0] ProgWordLen = 4'd7;
  localparam logic [3:0] ProgMatched = 4'd8;
  localparam logic [3:0] ProgFailed  = 4'd9;

  typedef enum logic [StatusW-1:0] {
    StMalformed = 3'd0,
    StBadHex    = 3'd1,
    StMismatch  = 3'd2,
    StValid     = 3'd3,
    StGoBoot    = 3'd4
  } nmea_status_e;

  typedef struct packed {
    logic [CntW-1:0] stored;
    logic [CntW-1:0] eff_len;
    logic            zero_seen;
    logic            dollar;
    logic [7:0]      xsum;
    logic [23:0]     last3;
    logic [3:0]      prog;
  } nmea_line_t;

  typedef struct packed {
    nmea_status_e status;
    logic         skipped;
  } nmea_verdict_t;

  localparam nmea_line_t LineClear = '0;

  function automatic logic [7:0] boot_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h47;
      3'd1:    ch = 8'h4F;
      3'd2:    ch = 8'h5F;
      3'd3:    ch = 8'h42;
      3'd4:    ch = 8'h4F;
      3'd5:    ch = 8'h4F;
      3'd6:    ch = 8'h54;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// File: rtl/nmea_if.sv
interface nmea_in_if;
  logic                       valid;
  logic                       ready;
  logic [nmea_pkg::PortW-1:0] port;
  logic [7:0]                 rx_byte;

  modport source (output valid, output port, output rx_byte, input ready);
  modport sink (input valid, input port, input rx_byte, output ready);
endinterface

interface nmea_out_if;
  logic                         valid;
  logic                         ready;
  logic [nmea_pkg::PortW-1:0]   line_port;
  logic [nmea_pkg::StatusW-1:0] line_status;
  logic                         check_skipped;

  modport source (output valid, output line_port, output line_status,
                  output check_skipped, input ready);
  modport sink (input valid, input line_port, input line_status,
                input check_skipped, output ready);
endinterface

// File: rtl/nmea_command_line_receiver_top.sv
// Channel  Dir  Payload                                  Transaction when
// rx_i     in   port, rx_byte                            valid && ready
// line_o   out  line_port, line_status, check_skipped    valid && ready
//
// One byte per cycle sustained; a byte is held in an input register and
// then updates its port's line state, loading the result register when it
// closes a line. Reset clears all port line state and empties both registers
// at once. A stalled result stalls a byte that closes a line and the bytes
// behind it; other bytes flow.
module nmea_command_line_receiver_top (
  input logic        clk_i,
  input logic        rst_ni,
  nmea_in_if.sink    rx_i,
  nmea_out_if.source line_o
);
  import nmea_pkg::*;

  logic             s1_valid_q;
  logic [PortW-1:0] s1_port_q;
  logic [7:0]       s1_byte_q;
  logic             out_valid_q;
  logic [PortW-1:0] out_port_q;
  logic [StatusW-1:0] out_status_q;
  logic             out_skip_q;

  logic          close;
  logic          advance;
  nmea_line_t    cur_line;
  nmea_verdict_t verdict;

  nmea_port_state u_state (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .port_i  (s1_port_q),
    .byte_i  (s1_byte_q),
    .close_o (close),
    .line_o  (cur_line)
  );

  nmea_line_judge u_judge (
    .line_i    (cur_line),
    .verdict_o (verdict)
  );

  assign advance  = s1_valid_q && (!close || !out_valid_q || line_o.ready);
  assign rx_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rx_i.valid && rx_i.ready) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance && close) begin
        out_valid_q <= 1'b1;
      end else if (line_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      s1_port_q <= rx_i.port;
      s1_byte_q <= rx_i.rx_byte;
    end
    if (advance && close) begin
      out_port_q   <= s1_port_q;
      out_status_q <= verdict.status;
      out_skip_q   <= verdict.skipped;
    end
  end

  assign line_o.valid         = out_valid_q;
  assign line_o.line_port     = out_port_q;
  assign line_o.line_status   = out_status_q;
  assign line_o.check_skipped = out_skip_q;

endmodule

// File: rtl/nmea_line_judge.sv
module nmea_line_judge (
  input  nmea_pkg::nmea_line_t    line_i,
  output nmea_pkg::nmea_verdict_t verdict_o
);
  import nmea_pkg::*;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else begin
      r = 5'd0;
    end
    return r;
  endfunction

  logic [7:0] star;
  logic [7:0] hi;
  logic [7:0] lo;
  logic [7:0] payload;
  logic [4:0] hex_hi;
  logic [4:0] hex_lo;
  nmea_status_e good;

  assign star    = line_i.last3[23:16];
  assign hi      = line_i.last3[15:8];
  assign lo      = line_i.last3[7:0];
  assign payload = line_i.xsum ^ star ^ hi ^ lo;
  assign hex_hi  = hex_value(hi);
  assign hex_lo  = hex_value(lo);
  assign good    = (line_i.prog == ProgMatched) ? StGoBoot : StValid;

  always_comb begin
    verdict_o.skipped = 1'b0;
    if (line_i.eff_len < MinLen || !line_i.dollar || star != ChStar) begin
      verdict_o.status = StMalformed;
    end else if (hi == ChX && lo == ChX) begin
      verdict_o.skipped = 1'b1;
      verdict_o.status  = good;
    end else if (!hex_hi[4] || !hex_lo[4]) begin
      verdict_o.status = StBadHex;
    end else if ({hex_hi[3:0], hex_lo[3:0]} != payload) begin
      verdict_o.status = StMismatch;
    end else begin
      verdict_o.status = good;
    end
  end

endmodule

// File: rtl/nmea_port_state.sv
module nmea_port_state (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [nmea_pkg::PortW-1:0] port_i,
  input  logic [7:0]                 byte_i,
  output logic                       close_o,
  output nmea_pkg::nmea_line_t       line_o
);
  import nmea_pkg::*;

  nmea_line_t line_q [Ports];
  nmea_line_t line_d;
  logic       port_ok;
  logic       close;

  assign port_ok = int'(port_i) < Ports;
  assign line_o  = line_q[port_i];
  assign close_o = close && port_ok;

  always_comb begin
    nmea_line_t cur;
    nmea_line_t base;
    cur    = line_q[port_i];
    base   = cur;
    line_d = cur;
    close  = 1'b0;
    if (byte_i == ChCr || byte_i == ChLf) begin
      if (cur.stored != '0) begin
        close  = 1'b1;
        line_d = LineClear;
      end
    end else begin
      base   = (byte_i == ChDollar) ? LineClear : cur;
      line_d = base;
      if (base.stored < CntMax) begin
        line_d.stored = base.stored + 1'b1;
        if (!base.zero_seen) begin
          if (byte_i == ChNul) begin
            line_d.zero_seen = 1'b1;
          end else begin
            if (base.eff_len == '0) begin
              line_d.dollar = (byte_i == ChDollar);
            end else begin
              line_d.xsum = base.xsum ^ byte_i;
              if (base.prog < ProgWordLen) begin
                line_d.prog = (byte_i == boot_char(base.prog[2:0])) ?
                              base.prog + 1'b1 : ProgFailed;
              end else if (base.prog == ProgWordLen) begin
                line_d.prog = (byte_i == ChComma || byte_i == ChStar) ?
                              ProgMatched : ProgFailed;
              end
            end
            line_d.last3   = {base.last3[15:0], byte_i};
            line_d.eff_len = base.eff_len + 1'b1;
          end
        end
      end else begin
        line_d = LineClear;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Ports; i++) begin
        line_q[i] <= LineClear;
      end
    end else if (en_i && port_ok) begin
      line_q[port_i] <= line_d;
    end
  end

endmodule

// File: rtl/nmea_checker.sv
`include "nmea_command_line_receiver_top_macros.svh"

module nmea_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         rx_valid_i,
  input logic                         rx_ready_i,
  input logic [7:0]                   rx_byte_i,
  input logic                         line_valid_i,
  input logic                         line_ready_i,
  input logic [nmea_pkg::PortW-1:0]   line_port_i,
  input logic [nmea_pkg::StatusW-1:0] line_status_i,
  input logic                         check_skipped_i
);
  import nmea_pkg::*;

  `NMEA_ASSERT_NEXT(a_line_hold, line_valid_i && !line_ready_i, line_valid_i && $stable(line_port_i) && $stable(line_status_i) && $stable(check_skipped_i))

  `NMEA_ASSERT_IMPL(a_skip_valid, line_valid_i && check_skipped_i, line_status_i == StValid || line_status_i == StGoBoot)

  `NMEA_ASSERT_IMPL(a_rise_after_eol, $rose(line_valid_i), $past(rx_valid_i && rx_ready_i && (rx_byte_i == ChCr || rx_byte_i == ChLf), 2))

endmodule

bind nmea_command_line_receiver_top nmea_checker u_nmea_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .rx_valid_i      (rx_i.valid),
  .rx_ready_i      (rx_i.ready),
  .rx_byte_i       (rx_i.rx_byte),
  .line_valid_i    (line_o.valid),
  .line_ready_i    (line_o.ready),
  .line_port_i     (line_o.line_port),
  .line_status_i   (line_o.line_status),
  .check_skipped_i (line_o.check_skipped)
);
